// ===== rtl/core/prq_pkg.sv =====
package prq_pkg;

  // Sizing of the queue.
  localparam int MAX_PACKETS = 16;
  localparam int MAX_MTU     = 512;
  localparam int DROP_WIDTH  = 32;

  localparam int SLOT_LIMIT  = MAX_PACKETS + 1;
  localparam int IDX_W       = $clog2(SLOT_LIMIT);
  localparam int CAP_W       = $clog2(MAX_PACKETS + 1);
  localparam int LEN_W       = $clog2(MAX_MTU + 1);
  localparam int OFF_W       = $clog2(MAX_MTU);
  localparam int BYTE_DEPTH  = SLOT_LIMIT * MAX_MTU;
  localparam int ADDR_W      = $clog2(BYTE_DEPTH);

  // Fixed field widths of the ports.
  localparam int BYTE_W      = 8;
  localparam int SEQ_W       = 64;
  localparam int ROOM_W      = 10;
  localparam int PLEN_W      = 10;
  localparam int DEPTH_W     = 5;
  localparam int DROP_OUT_W  = 32;
  localparam int SLOTS_CFG_W = 5;
  localparam int MTU_CFG_W   = 10;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 10;

  localparam int S_FIELDS_W  = BYTE_W + SEQ_W + ROOM_W;
  localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_FIELDS_W  = BYTE_W + PLEN_W + SEQ_W + 2 * DEPTH_W + DROP_OUT_W;
  localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
  localparam int M_PAD_W     = M_TDATA_W - M_FIELDS_W;

  localparam logic [SLOTS_CFG_W-1:0] SLOTS_RESET = SLOTS_CFG_W'(16);
  localparam logic [MTU_CFG_W-1:0]   MTU_RESET   = MTU_CFG_W'(500);

  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MTU   = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    ACT_WRITE   = 2'd0,
    ACT_READ    = 2'd1,
    ACT_DISCARD = 2'd2,
    ACT_QUERY   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_BAD_LEN = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_ROOM    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_EMIT = 2'd2
  } fsm_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
  } prq_cmd_t;

  typedef struct packed {
    logic out_free;
  } prq_stat_t;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i,
                                                 input logic [CAP_W-1:0] cap);
    logic [IDX_W:0] n;
    logic [IDX_W:0] lim;
    n   = (IDX_W+1)'(i) + 1'b1;
    lim = (IDX_W+1)'(cap) + 1'b1;
    return (n >= lim) ? '0 : n[IDX_W-1:0];
  endfunction

  function automatic logic [CAP_W-1:0] ring_depth(input logic [IDX_W-1:0] tail,
                                                  input logic [IDX_W-1:0] head,
                                                  input logic [CAP_W-1:0] cap);
    logic [IDX_W:0] d;
    if (tail >= head) begin
      d = (IDX_W+1)'(tail) - (IDX_W+1)'(head);
    end else begin
      d = (IDX_W+1)'(cap) + 1'b1 - (IDX_W+1)'(head) + (IDX_W+1)'(tail);
    end
    return d[CAP_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] byte_addr(input logic [IDX_W-1:0] slot,
                                                  input logic [OFF_W-1:0] off);
    return ADDR_W'(slot) * ADDR_W'(MAX_MTU) + ADDR_W'(off);
  endfunction

endpackage

// ===== rtl/core/prq_byte_ram.sv =====
module prq_byte_ram
  import prq_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [BYTE_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem [0:BYTE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/prq_ctrl.sv =====
module prq_ctrl
  import prq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  prq_stat_t stat,
  output prq_cmd_t  cmd
);

  fsm_t state;
  fsm_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Idle takes an item, the next cycle executes it, then the result waits for
  // the output register to be free.
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/prq_datapath.sv =====
module prq_datapath
  import prq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [S_TDATA_W-1:0]  in_tdata,
  input  logic [1:0]            in_tuser,
  input  logic                  in_tlast,
  input  prq_cmd_t              cmd,
  output prq_stat_t             stat,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,
  output logic [2:0]            m_tuser,
  output logic                  m_tlast
);

  // Configuration registers.
  logic [SLOTS_CFG_W-1:0] slots_cfg;
  logic [MTU_CFG_W-1:0]   mtu_cfg;
  logic [CAP_W-1:0]       cap;
  logic [LEN_W-1:0]       mtu;

  // Queue state.
  logic [IDX_W-1:0]      tail;
  logic [IDX_W-1:0]      head;
  logic [LEN_W-1:0]      cnt;
  logic                  ovf;
  logic [LEN_W-1:0]      roff;
  logic [CAP_W-1:0]      hw;
  logic [DROP_WIDTH-1:0] drops;

  logic [LEN_W-1:0] length_store [0:SLOT_LIMIT-1];
  logic [SEQ_W-1:0] seq_store    [0:SLOT_LIMIT-1];

  // Captured item.
  action_t          act;
  logic [BYTE_W-1:0] dbyte;
  logic             eop;
  logic [SEQ_W-1:0] seq_in;
  logic [ROOM_W-1:0] room;

  // Pending result of the executed item.
  status_t          res_status;
  logic             res_last;
  logic [LEN_W-1:0] res_plen;
  logic [SEQ_W-1:0] res_seq;
  logic             res_rd;

  // Output register.
  status_t           out_status;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;
  logic [PLEN_W-1:0] out_plen;
  logic [SEQ_W-1:0]  out_seq;
  logic [DEPTH_W-1:0] out_fill;
  logic [DEPTH_W-1:0] out_peak;
  logic [DROP_OUT_W-1:0] out_drop;

  // Next values computed while executing.
  logic [IDX_W-1:0]      tail_next;
  logic [IDX_W-1:0]      head_next;
  logic [LEN_W-1:0]      cnt_next;
  logic                  ovf_next;
  logic [LEN_W-1:0]      roff_next;
  logic [CAP_W-1:0]      hw_next;
  logic [DROP_WIDTH-1:0] drops_next;
  status_t               status_next;
  logic                  last_next;
  logic [LEN_W-1:0]      plen_next;
  logic [SEQ_W-1:0]      seq_next;
  logic                  commit;
  logic                  wr_en;
  logic                  rd_en;

  logic [LEN_W-1:0]  cnt_after;
  logic              ovf_after;
  logic [IDX_W-1:0]  tail_adv;
  logic [IDX_W-1:0]  head_adv;
  logic [CAP_W-1:0]  depth_commit;
  logic [LEN_W-1:0]  head_len;
  logic [LEN_W-1:0]  roff_inc;
  logic [OFF_W-1:0]  roff_idx;
  logic              empty;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [BYTE_W-1:0] ram_rdata;

  assign cap = (slots_cfg == '0) ? CAP_W'(1) :
               (slots_cfg > SLOTS_CFG_W'(MAX_PACKETS)) ? CAP_W'(MAX_PACKETS) :
               CAP_W'(slots_cfg);
  assign mtu = (mtu_cfg > MTU_CFG_W'(MAX_MTU)) ? LEN_W'(MAX_MTU) : LEN_W'(mtu_cfg);

  assign empty        = (head == tail);
  assign tail_adv     = ring_next(tail, cap);
  assign head_adv     = ring_next(head, cap);
  assign depth_commit = ring_depth(tail_adv, head, cap);
  assign head_len     = length_store[head];
  assign roff_inc     = roff + 1'b1;
  assign roff_idx     = (roff < LEN_W'(MAX_MTU)) ? roff[OFF_W-1:0] : OFF_W'(MAX_MTU - 1);
  assign wr_addr      = byte_addr(tail, cnt[OFF_W-1:0]);
  assign rd_addr      = byte_addr(head, roff_idx);

  always_comb begin
    tail_next   = tail;
    head_next   = head;
    cnt_next    = cnt;
    ovf_next    = ovf;
    roff_next   = roff;
    hw_next     = hw;
    drops_next  = drops;
    status_next = ST_OK;
    last_next   = 1'b0;
    plen_next   = '0;
    seq_next    = '0;
    commit      = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    cnt_after   = cnt;
    ovf_after   = ovf;
    case (act)
      ACT_WRITE: begin
        // Bytes past the mtu are not stored, only remembered as overflow.
        if (cnt < mtu) begin
          wr_en     = 1'b1;
          cnt_after = cnt + 1'b1;
        end else begin
          ovf_after = 1'b1;
        end
        cnt_next = cnt_after;
        ovf_next = ovf_after;
        if (eop) begin
          if (ovf_after || (cnt_after == '0)) begin
            status_next = ST_BAD_LEN;
          end else if (tail_adv == head) begin
            status_next = ST_FULL;
            drops_next  = drops + 1'b1;
          end else begin
            commit    = 1'b1;
            tail_next = tail_adv;
            if (depth_commit > hw) begin
              hw_next = depth_commit;
            end
          end
          cnt_next = '0;
          ovf_next = 1'b0;
        end
      end
      ACT_READ: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          plen_next = head_len;
          seq_next  = seq_store[head];
          if ((roff == '0) && (LEN_W'(room) < head_len)) begin
            status_next = ST_ROOM;
          end else begin
            rd_en = 1'b1;
            if (roff_inc >= head_len) begin
              last_next = 1'b1;
              roff_next = '0;
              head_next = head_adv;
            end else begin
              roff_next = roff_inc;
            end
          end
        end
      end
      ACT_DISCARD: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          head_next = head_adv;
          roff_next = '0;
        end
      end
      ACT_QUERY: begin
        status_next = ST_OK;
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  prq_byte_ram u_ram (
    .clk   (clk),
    .we    (cmd.exec && wr_en),
    .waddr (wr_addr),
    .wdata (dbyte),
    .re    (cmd.exec && rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act    <= action_t'(in_tuser);
      dbyte  <= in_tdata[BYTE_W-1:0];
      seq_in <= in_tdata[BYTE_W +: SEQ_W];
      room   <= in_tdata[BYTE_W + SEQ_W +: ROOM_W];
      eop    <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_status <= status_next;
      res_last   <= last_next;
      res_plen   <= plen_next;
      res_seq    <= seq_next;
      res_rd     <= rd_en;
      if (commit) begin
        length_store[tail] <= cnt_after;
        seq_store[tail]    <= seq_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_cfg <= SLOTS_RESET;
      mtu_cfg   <= MTU_RESET;
      tail      <= '0;
      head      <= '0;
      cnt       <= '0;
      ovf       <= 1'b0;
      roff      <= '0;
      hw        <= '0;
      drops     <= '0;
    end else if (cfg_we && ((cfg_index == CFG_SLOTS) || (cfg_index == CFG_MTU))) begin
      if (cfg_index == CFG_SLOTS) begin
        slots_cfg <= cfg_data[SLOTS_CFG_W-1:0];
      end else begin
        mtu_cfg <= cfg_data[MTU_CFG_W-1:0];
      end
      tail  <= '0;
      head  <= '0;
      cnt   <= '0;
      ovf   <= 1'b0;
      roff  <= '0;
      hw    <= '0;
      drops <= '0;
    end else if (cmd.exec) begin
      tail  <= tail_next;
      head  <= head_next;
      cnt   <= cnt_next;
      ovf   <= ovf_next;
      roff  <= roff_next;
      hw    <= hw_next;
      drops <= drops_next;
    end
  end

  // Output register; the counters are sampled after the item has updated them.
  assign stat.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_status <= res_status;
      out_byte   <= res_rd ? ram_rdata : '0;
      out_last   <= res_last;
      out_plen   <= PLEN_W'(res_plen);
      out_seq    <= res_seq;
      out_fill   <= DEPTH_W'(ring_depth(tail, head, cap));
      out_peak   <= DEPTH_W'(hw);
      out_drop   <= DROP_OUT_W'(drops);
    end
  end

  assign m_tdata = {{M_PAD_W{1'b0}}, out_drop, out_peak, out_fill,
                    out_seq, out_plen, out_byte};
  assign m_tuser = out_status;
  assign m_tlast = out_last;

endmodule

// ===== rtl/core/packet_ring_queue_top.sv =====
// Flow: a transfer accepted in idle is executed in the next cycle, and its
// result is then registered onto the master side once the output register is free.
// No new item is accepted until that result has been loaded; back-pressure on the
// result side therefore holds the input side too.
// Reset: rst is synchronous and active high; it restores the default configuration and
// empties the queue at once, with no clearing pass over the packet memory.
module packet_ring_queue_top
  import prq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write port: index 0 is the queue capacity, index 1 is the MTU.
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Input stream.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,  // data_byte, packet_seq_in, reader_room, zero pad
  input  logic [1:0]            s_tuser,  // action
  input  logic                  s_tlast,  // end_of_packet
  // Result stream, one transfer per accepted item.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,  // read_byte, packet_length, packet_seq_out,
                                          // fill_depth, peak_depth, drop_count, zero pad
  output logic [2:0]            m_tuser,  // status
  output logic                  m_tlast   // last_byte
);

  // The controller sequences each item through capture, execute and result
  // load. The datapath holds the queue state, the packet byte memory, the
  // per-slot length and sequence registers and the output register.
  prq_cmd_t  cmd;
  prq_stat_t stat;

  prq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  prq_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tdata  (s_tdata),
    .in_tuser  (s_tuser),
    .in_tlast  (s_tlast),
    .cmd       (cmd),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  // Field views of the result for the checks below.
  logic [DEPTH_W-1:0] chk_fill;
  logic [DEPTH_W-1:0] chk_peak;

  assign chk_fill = m_tdata[BYTE_W + PLEN_W + SEQ_W +: DEPTH_W];
  assign chk_peak = m_tdata[BYTE_W + PLEN_W + SEQ_W + DEPTH_W +: DEPTH_W];

  // Only one item is in flight: after a transfer the input side closes.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while an item is still in flight");

  // The high-water mark can never be below the current depth.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (chk_fill <= chk_peak))
    else $error("fill depth above peak depth");

  // A popped packet always comes with a good status.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tuser == ST_OK))
    else $error("last byte flagged on a failed action");

  // A result is loaded only when the output register is free.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result overwritten");

endmodule
